/* rtl/slp_pkg.sv */
// package for the slew limited position tracker
// holds the fixed-point width, default speed, event kinds and the divider status type
// no dependencies
package slp_pkg;

    localparam int FRAC_BITS     = 10;
    localparam int CNT_W         = $clog2(FRAC_BITS + 1);
    localparam int POS_W         = 16;
    localparam int SPEED_W       = 16;
    localparam int TIME_W        = 32;
    localparam int STEP_W        = TIME_W - FRAC_BITS;

    localparam logic [SPEED_W-1:0] DEFAULT_SPEED = 16'd300;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_SET_TGT  = 2'd1,
        KIND_SET_CUR  = 2'd2,
        KIND_UNUSED   = 2'd3
    } kind_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* rtl/slew_limited_position_tracker.sv */
// slew limited position tracker: moves a position toward a target at the configured speed
// a tick word passes through the multiply, divider start, divider wait and finish states; set words
// go straight to finish. one word at a time: a new word is taken only back in idle, after finish,
// which holds while the result is stalled
// reset: aresetn synchronous active low; position, target, residual, time base cleared,
// tracker not moving, speed back to 300. depends on slp_pkg, slp_cfg, slp_div
module slew_limited_position_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // value[15:0], now_ms[47:16]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // position[15:0]
    output logic [0:0]  m_tuser,   // moving[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import slp_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MUL    = 5'b00010,
        ST_DSTART = 5'b00100,
        ST_DWAIT  = 5'b01000,
        ST_FIN    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [SPEED_W-1:0]   speed;
    logic [POS_W-1:0]     cur_reg, cur_next;
    logic [POS_W-1:0]     tgt_reg, tgt_next;
    logic [FRAC_BITS-1:0] resid_reg, resid_next;
    logic [TIME_W-1:0]    last_reg, last_next;
    logic                 run_reg, run_next;

    kind_t                kind_reg;
    logic [POS_W-1:0]     val_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [TIME_W-1:0]    prod_reg;

    logic                 mvalid_reg, mvalid_next;
    logic [POS_W-1:0]     mpos_reg;
    logic                 mmov_reg;

    logic [TIME_W-1:0]    elapsed;
    logic [TIME_W-1:0]    prod_full;
    logic [FRAC_BITS-1:0] quotient;
    div_stat_t            div_stat;
    logic                 div_start;

    logic                 accept, fin_go, upd_run, armed;
    logic signed [POS_W:0] delta;
    logic [POS_W-1:0]     distance;
    logic [STEP_W-1:0]    step_raw;
    logic [POS_W-1:0]     step;
    logic [POS_W-1:0]     cur_mid, tgt_mid;

    slp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .speed   (speed)
    );

    slp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg[FRAC_BITS-1:0]),
        .divisor  (speed),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign div_start = (state_reg == ST_DSTART);
    assign fin_go    = (state_reg == ST_FIN) && (!mvalid_reg || m_tready);

    assign elapsed   = now_reg - last_reg + {{(TIME_W-FRAC_BITS){1'b0}}, resid_reg};
    assign prod_full = TIME_W'(elapsed * {{(TIME_W-SPEED_W){1'b0}}, speed});

    // distance to target and clamped step
    assign delta    = $signed({tgt_reg[POS_W-1], tgt_reg}) - $signed({cur_reg[POS_W-1], cur_reg});
    assign distance = delta[POS_W] ? POS_W'(-delta) : delta[POS_W-1:0];
    assign step_raw = prod_reg[TIME_W-1:FRAC_BITS];
    assign step     = (step_raw > {{(STEP_W-POS_W){1'b0}}, distance}) ?
                      distance : step_raw[POS_W-1:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) begin
                           state_next = (kind_t'(s_tuser) == KIND_TICK) ? ST_MUL : ST_FIN;
                       end
            ST_MUL:    state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DWAIT;
            ST_DWAIT:  if (div_stat.done) begin
                           state_next = ST_FIN;
                       end
            ST_FIN:    if (fin_go) begin
                           state_next = ST_IDLE;
                       end
            default:   state_next = ST_IDLE;
        endcase
    end

    // state update for the finished event
    always_comb begin
        cur_mid    = cur_reg;
        tgt_mid    = tgt_reg;
        upd_run    = run_reg;
        resid_next = resid_reg;
        last_next  = last_reg;
        unique case (kind_reg)
            KIND_TICK: begin
                if (!delta[POS_W] && delta != '0) begin
                    cur_mid = cur_reg + step;
                end else if (delta[POS_W]) begin
                    cur_mid = cur_reg - step;
                end
                resid_next = quotient;
                last_next  = now_reg;
                upd_run    = 1'b0;
            end
            KIND_SET_TGT: tgt_mid = val_reg;
            KIND_SET_CUR: cur_mid = val_reg;
            KIND_UNUSED:  ;
            default:      ;
        endcase
        armed = 1'b0;
        if (kind_reg != KIND_UNUSED && cur_mid != tgt_mid && !upd_run) begin
            armed = 1'b1;
        end
        cur_next = cur_mid;
        tgt_next = tgt_mid;
        run_next = upd_run || armed;
        if (armed) begin
            last_next = now_reg;
        end
    end

    always_comb begin
        mvalid_next = mvalid_reg;
        if (m_tready) begin
            mvalid_next = 1'b0;
        end
        if (fin_go) begin
            mvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cur_reg    <= '0;
            tgt_reg    <= '0;
            resid_reg  <= '0;
            last_reg   <= '0;
            run_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            if (fin_go) begin
                cur_reg   <= cur_next;
                tgt_reg   <= tgt_next;
                resid_reg <= resid_next;
                last_reg  <= last_next;
                run_reg   <= run_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= kind_t'(s_tuser);
            val_reg  <= s_tdata[POS_W-1:0];
            now_reg  <= s_tdata[POS_W+TIME_W-1:POS_W];
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= prod_full;
        end
        if (fin_go) begin
            mpos_reg <= cur_next;
            mmov_reg <= run_next && (cur_next != tgt_next);
        end
    end

    assign m_tvalid   = mvalid_reg;
    assign m_tdata    = mpos_reg;
    assign m_tuser[0] = mmov_reg;

endmodule

/* rtl/slp_cfg.sv */
// apb register block holding the speed register
// depends on slp_pkg
module slp_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [slp_pkg::SPEED_W-1:0] speed
);
    import slp_pkg::*;

    logic [SPEED_W-1:0] speed_reg;
    logic [SPEED_W-1:0] speed_next;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == 3'd0);

    always_comb begin
        speed_next = speed_reg;
        if (wr_en) begin
            // zero would stall motion, fall back to the default
            speed_next = (pwdata[SPEED_W-1:0] == '0) ? DEFAULT_SPEED : pwdata[SPEED_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg <= DEFAULT_SPEED;
        end else begin
            speed_reg <= speed_next;
        end
    end

    assign prdata = (paddr == 3'd0) ? {{(32-SPEED_W){1'b0}}, speed_reg} : 32'd0;
    assign speed  = speed_reg;

endmodule

/* rtl/slp_div.sv */
// iterative restoring divider, one quotient bit per cycle
// divides the fractional product bits by the speed; depends on slp_pkg
module slp_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [slp_pkg::FRAC_BITS-1:0] dividend,
    input  logic [slp_pkg::SPEED_W-1:0]   divisor,
    output logic [slp_pkg::FRAC_BITS-1:0] quotient,
    output slp_pkg::div_stat_t            stat
);
    import slp_pkg::*;

    logic [SPEED_W-1:0]   rem_reg, rem_next;
    logic [FRAC_BITS-1:0] dvd_reg, dvd_next;
    logic [FRAC_BITS-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [SPEED_W:0]     trial;
    logic                 fits;

    assign trial = {rem_reg, dvd_reg[FRAC_BITS-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            dvd_next  = dividend;
            quo_next  = '0;
            cnt_next  = CNT_W'(FRAC_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so it fits back in SPEED_W bits
            rem_next = fits ? SPEED_W'(trial - {1'b0, divisor}) : trial[SPEED_W-1:0];
            dvd_next = {dvd_reg[FRAC_BITS-2:0], 1'b0};
            quo_next = {quo_reg[FRAC_BITS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* verif/slp_track_checker.sv */
// checker for the slew limited position tracker: watches the input, result and apb ports,
// predicts each result word from its own copy of the tracker state and compares in order
// depends on slp_pkg
module slp_track_checker
    import slp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // value[15:0], now_ms[47:16]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // position[15:0]
    input  logic [0:0]  m_tuser,   // moving[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending_count
);

    localparam logic [2:0] ADDR_SPEED = 3'd0;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             moving;
    } track_word_t;

    track_word_t       expected_track[$];
    logic [POS_W-1:0]  cur_pos;
    logic [POS_W-1:0]  tgt_pos;
    logic [TIME_W-1:0] resid_ms;
    logic [TIME_W-1:0] time_base;
    logic              armed;
    logic [SPEED_W-1:0] speed_reg;

    function automatic void arm_motion(logic [TIME_W-1:0] now);
        if (cur_pos != tgt_pos && !armed) begin
            time_base = now;
            armed     = 1'b1;
        end
    endfunction

    function automatic void advance_position(logic [TIME_W-1:0] now);
        logic [TIME_W-1:0]        elapsed;
        logic [TIME_W-1:0]        prod;
        logic [TIME_W-1:0]        step_units;
        logic [TIME_W-1:0]        distance;
        logic signed [TIME_W-1:0] delta;
        elapsed    = now - time_base + resid_ms;
        time_base  = now;
        prod       = elapsed * {16'd0, speed_reg};
        resid_ms   = (prod & ((32'd1 << FRAC_BITS) - 32'd1)) / {16'd0, speed_reg};
        step_units = prod >> FRAC_BITS;
        // signed distance between the two 16-bit positions, no wrap
        delta = $signed({{16{tgt_pos[15]}}, tgt_pos}) - $signed({{16{cur_pos[15]}}, cur_pos});
        distance = (delta < 0) ? -delta : delta;
        if (step_units > distance) begin
            step_units = distance;
        end
        if (delta > 0) begin
            cur_pos = cur_pos + step_units[POS_W-1:0];
        end else if (delta < 0) begin
            cur_pos = cur_pos - step_units[POS_W-1:0];
        end
        // the one-shot timer has fired
        armed = 1'b0;
        arm_motion(now);
    endfunction

    function automatic void report_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
        if (fail_count < 10) begin
            $display("slp_track_checker: %s mismatch at %0t: expected %0h, got %0h",
                     what, $realtime, exp_v, act_v);
        end
        fail_count++;
    endfunction

    always @(posedge aclk) begin
        track_word_t exp_w;
        if (!aresetn) begin
            cur_pos   = '0;
            tgt_pos   = '0;
            resid_ms  = '0;
            time_base = '0;
            armed     = 1'b0;
            speed_reg = DEFAULT_SPEED;
            expected_track.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_SPEED) begin
                speed_reg = (pwdata[15:0] == '0) ? DEFAULT_SPEED : pwdata[15:0];
            end
            if (s_tvalid && s_tready) begin
                case (kind_t'(s_tuser))
                    KIND_TICK: begin
                        advance_position(s_tdata[47:16]);
                    end
                    KIND_SET_TGT: begin
                        tgt_pos = s_tdata[15:0];
                        arm_motion(s_tdata[47:16]);
                    end
                    KIND_SET_CUR: begin
                        cur_pos = s_tdata[15:0];
                        arm_motion(s_tdata[47:16]);
                    end
                    default: begin
                        // unused kind leaves the state alone
                    end
                endcase
                expected_track.push_back('{position: cur_pos,
                                           moving: armed && (cur_pos != tgt_pos)});
            end
            if (m_tvalid && m_tready) begin
                if (expected_track.size() == 0) begin
                    report_mismatch("unexpected word, position", 32'hx, {16'd0, m_tdata});
                end else begin
                    exp_w = expected_track.pop_front();
                    if (m_tdata !== exp_w.position) begin
                        report_mismatch("position", {16'd0, exp_w.position}, {16'd0, m_tdata});
                    end
                    if (m_tuser[0] !== exp_w.moving) begin
                        report_mismatch("moving", {31'd0, exp_w.moving}, {31'd0, m_tuser[0]});
                    end
                end
            end
        end
        pending_count = expected_track.size();
    end

endmodule

/* verif/tb_slew_limited_position_tracker.sv */
// testbench top for the slew limited position tracker: clock, reset, stimulus and verdict
// directed words, then phases of random words at several speeds; depends on slp_pkg,
// slp_track_checker and the tracker rtl
module tb_slew_limited_position_tracker;
    import slp_pkg::*;

    localparam logic [2:0] ADDR_SPEED  = 3'd0;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         PHASE_WORDS = 100;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // value[15:0], now_ms[47:16]
    logic [1:0]  s_tuser;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // position[15:0]
    logic [0:0]  m_tuser;   // moving[0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending_count;
    int          cycles;
    int          rx_hold;
    logic        tx_calm;
    logic        rx_calm;
    logic [31:0] clock_ms;

    slew_limited_position_tracker dut (.*);

    slp_track_checker u_checker (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .fail_count, .pending_count
    );

    initial begin
        aclk = 1'b0;
    end

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_slew_limited_position_tracker: done, errors");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready = 1'b0;
        end else if (!rx_calm && $urandom_range(9) < 3) begin
            rx_hold  = gap_len() - 1;
            m_tready = 1'b0;
        end else begin
            m_tready = 1'b1;
        end
    end

    // called and returns at a falling edge; tvalid stays high until the next call
    task automatic send_word(kind_t kind, logic [15:0] value, logic [31:0] now);
        int gap;
        gap = (!tx_calm && $urandom_range(9) < 3) ? gap_len() : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {now, value};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_speed(logic [15:0] speed);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_SPEED;
        pwdata  = {16'($urandom), speed};
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic logic [31:0] time_advance();
        int r;
        r = $urandom_range(99);
        if (r < 70) begin
            return $urandom_range(1, 64);
        end else if (r < 95) begin
            return $urandom_range(500, 20000);
        end
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_position();
        if ($urandom_range(1)) begin
            return 16'($urandom_range(0, 512)) - 16'd256;
        end
        return 16'($urandom);
    endfunction

    task automatic random_phase();
        int r;
        repeat (PHASE_WORDS) begin
            r = $urandom_range(99);
            if (r < 55) begin
                clock_ms += time_advance();
                send_word(KIND_TICK, 16'($urandom), clock_ms);
            end else if (r < 70) begin
                clock_ms += $urandom_range(0, 20);
                send_word(KIND_SET_TGT, pick_position(), clock_ms);
            end else if (r < 80) begin
                clock_ms += $urandom_range(0, 20);
                send_word(KIND_SET_CUR, pick_position(), clock_ms);
            end else if (r < 85) begin
                send_word(KIND_UNUSED, 16'($urandom), $urandom);
            end else if (r < 92) begin
                // tick with a time that jumps anywhere, including backwards
                clock_ms = $urandom;
                send_word(KIND_TICK, 16'($urandom), clock_ms);
            end else begin
                clock_ms = $urandom;
                send_word(kind_t'($urandom_range(1, 2)), 16'($urandom), clock_ms);
            end
        end
    endtask

    initial begin
        logic [15:0] speeds [7];
        tx_calm  = 1'b0;
        rx_calm  = 1'b0;
        clock_ms = '0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset speed: tick while idle, ignored kind, start, move, clamp onto target
        send_word(KIND_TICK, 16'h0000, 32'd0);
        send_word(KIND_UNUSED, 16'hffff, 32'hffff_ffff);
        send_word(KIND_SET_TGT, 16'd1000, 32'd100);
        send_word(KIND_TICK, 16'h0000, 32'd1124);
        send_word(KIND_TICK, 16'h0000, 32'd6124);
        // extreme positions and a tick across the clock wrap
        send_word(KIND_SET_CUR, 16'h8000, 32'hffff_ff00);
        send_word(KIND_SET_TGT, 16'h7fff, 32'hffff_ff10);
        send_word(KIND_TICK, 16'h0000, 32'h0000_0100);
        send_word(KIND_TICK, 16'h0000, 32'h0010_0000);
        send_word(KIND_UNUSED, 16'h7fff, 32'h0000_0000);
        send_word(KIND_SET_TGT, 16'h8000, 32'h5555_5555);
        send_word(KIND_SET_CUR, 16'h0000, 32'haaaa_aaaa);
        send_word(KIND_TICK, 16'hffff, 32'haaab_aaaa);
        // target reached while the timer is still armed
        send_word(KIND_SET_CUR, 16'h8000, 32'haaab_aaab);
        wait_idle();

        // fastest speed, product wraps modulo 2^32
        write_speed(16'hffff);
        send_word(KIND_SET_TGT, 16'h7fff, 32'd10);
        send_word(KIND_TICK, 16'h0000, 32'd11);
        send_word(KIND_TICK, 16'h0000, 32'd100011);
        send_word(KIND_SET_CUR, 16'hc000, 32'd100012);
        send_word(KIND_TICK, 16'h0000, 32'd100013);
        wait_idle();

        // slowest speed, residual carries over between ticks
        write_speed(16'd1);
        send_word(KIND_SET_TGT, 16'h8000, 32'd200);
        send_word(KIND_TICK, 16'h0000, 32'd900);
        send_word(KIND_TICK, 16'h0000, 32'd1700);
        send_word(KIND_TICK, 16'h0000, 32'd5000);
        wait_idle();

        speeds = '{16'd1, 16'hffff, 16'd0, 16'($urandom_range(2, 2000)),
                   16'($urandom), 16'd300, 16'($urandom_range(100, 900))};
        for (int p = 0; p < 7; p++) begin
            write_speed(speeds[p]);
            tx_calm = (p == 2);
            rx_calm = (p == 2) || (p == 5);
            random_phase();
            wait_idle();
        end

        if (fail_count == 0 && pending_count == 0) begin
            $display("tb_slew_limited_position_tracker: done, clean");
        end else begin
            $display("tb_slew_limited_position_tracker: done, errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/slp_pkg.sv
rtl/slp_cfg.sv
rtl/slp_div.sv
rtl/slew_limited_position_tracker.sv
verif/slp_track_checker.sv
verif/tb_slew_limited_position_tracker.sv
